/* rtl/swrl_pkg.sv */
// Shared constants, register indexes and a saturating-add helper for the sliding-window rate limiter.
`timescale 1ns / 1ps

package swrl_pkg;

	localparam int DEFAULT_HISTORY_DEPTH = 256;

	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 9;
	localparam int RATE_W   = 8;
	localparam int FACTOR_W = 9;
	localparam int WINDOW_W = 16;
	localparam int LIMIT_W  = RATE_W + FACTOR_W;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd2;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [RATE_W-1:0]   MAX_RATE_RST = 8'd0;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 9'd256;
	localparam logic [WINDOW_W-1:0] WINDOW_RST   = 16'd3600;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

/* rtl/sliding_window_rate_limiter_unit.sv */
// Top level of the sliding-window log rate limiter.
`timescale 1ns / 1ps

// A record word (cmd 0) is taken while busy is low and leaves busy low; with has_flight set it
// stores now_sec in the next ring slot, overwriting the oldest one once the ring is full.
// A query word (cmd 1) scans the n stored times (n = records stored so far, at most HISTORY_DEPTH)
// through the ring's single read port, one entry per cycle: busy stays high through the scan
// and a finish state, and the result word appears with done high for exactly one cycle, in
// the first cycle with busy low again. The receiver cannot stall; done is never repeated,
// so the result must be captured in that cycle. Write configuration only while busy is low.

module sliding_window_rate_limiter_unit #(
	parameter int HISTORY_DEPTH = swrl_pkg::DEFAULT_HISTORY_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [swrl_pkg::TIME_W-1:0]    now_sec,
	input  logic                           has_flight,
	input  logic                           cfg_we,
	input  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [swrl_pkg::CFG_W-1:0]     cfg_data,
	output logic                           done,
	output logic                           can_accept,
	output logic [swrl_pkg::COUNT_W-1:0]   count_in_window,
	output logic [swrl_pkg::TIME_W-1:0]    next_time
);
	import swrl_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [RATE_W-1:0]   max_rate_q;
	logic [FACTOR_W-1:0] rate_factor_q;
	logic [WINDOW_W-1:0] window_q;

	logic [AW:0]         idx_q;
	logic                vld_s1;
	logic [TIME_W-1:0]   start_q;
	logic [TIME_W-1:0]   now_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TIME_W-1:0]   oldest_q;
	logic                done_q;
	logic                can_accept_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic [TIME_W-1:0]   next_time_q;

	logic                accept;
	logic                wr_en;
	logic                rd_en;
	logic [TIME_W-1:0]   rd_data;
	logic [AW:0]         fill;
	logic [FACTOR_W-1:0] factor;
	logic [LIMIT_W-1:0]  limit_d;
	logic [TIME_W-1:0]   win_ext;
	logic [TIME_W-1:0]   start_d;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign wr_en   = accept && (cmd == CMD_RECORD) && has_flight;
	assign rd_en   = (state_q == ST_SCAN) && (idx_q != fill);
	assign win_ext = {{(TIME_W-WINDOW_W){1'b0}}, window_q};
	assign start_d = (now_sec >= win_ext) ? now_sec - win_ext : '0;
	assign factor  = (rate_factor_q > FACTOR_ONE) ? FACTOR_ONE : rate_factor_q;
	assign limit_d = {{FACTOR_W{1'b0}}, max_rate_q} * {{RATE_W{1'b0}}, factor};

	swrl_hist #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (now_sec),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data),
		.fill    (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q    <= MAX_RATE_RST;
			rate_factor_q <= FACTOR_ONE;
			window_q      <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_RATE:    max_rate_q    <= cfg_data[RATE_W-1:0];
				REG_RATE_FACTOR: rate_factor_q <= cfg_data[FACTOR_W-1:0];
				REG_WINDOW_LEN:  window_q      <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			idx_q        <= '0;
			start_q      <= '0;
			now_q        <= '0;
			limit_q      <= '0;
			count_q      <= '0;
			oldest_q     <= '1;
			can_accept_q <= 1'b0;
			count_out_q  <= '0;
			next_time_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (vld_s1 && (rd_data >= start_q)) begin
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
				if (rd_data < oldest_q) begin
					oldest_q <= rd_data;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_QUERY)) begin
						state_q  <= ST_SCAN;
						idx_q    <= '0;
						start_q  <= start_d;
						now_q    <= now_sec;
						limit_q  <= limit_d;
						count_q  <= '0;
						oldest_q <= '1;
					end
				end
				ST_SCAN: begin
					// last read data is folded in at the edge that leaves this state
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q     <= ST_IDLE;
					done_q      <= 1'b1;
					count_out_q <= count_q;
					if (limit_q == '0) begin
						can_accept_q <= 1'b0;
						next_time_q  <= sat_add(now_q, win_ext);
					end else if ({count_q, 8'd0} < limit_q) begin
						can_accept_q <= 1'b1;
						next_time_q  <= now_q;
					end else begin
						can_accept_q <= 1'b0;
						next_time_q  <= sat_add(oldest_q, win_ext);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign can_accept      = can_accept_q;
	assign count_in_window = count_out_q;
	assign next_time       = next_time_q;

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result word without a finished scan");

	a_accept_now: assert property (@(posedge clk) disable iff (!arst_n)
		(done && can_accept) |-> (next_time == now_q))
		else $error("capacity result does not report query time");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= fill))
		else $error("scan index past fill count");

	a_ring_stable: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(fill))
		else $error("ring changed during a scan");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data outside a scan");

endmodule

/* rtl/swrl_hist.sv */
// Ring of recent event times: one-port-per-direction memory, write pointer and fill count.
`timescale 1ns / 1ps

module swrl_hist #(
	parameter int DEPTH = swrl_pkg::DEFAULT_HISTORY_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [swrl_pkg::TIME_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [swrl_pkg::TIME_W-1:0] rd_data,
	output logic [AW:0]                fill
);
	import swrl_pkg::*;

	logic [TIME_W-1:0] mem [DEPTH];
	logic [TIME_W-1:0] rd_data_q;
	logic [AW-1:0]     wr_ptr_q;
	logic              full_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			full_q   <= 1'b0;
		end else if (wr_en) begin
			if (wr_ptr_q == AW'(DEPTH - 1)) begin
				wr_ptr_q <= '0;
				full_q   <= 1'b1;
			end else begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
		end
	end

	// entries below the write pointer are valid until the ring has wrapped once
	assign fill    = full_q ? (AW+1)'(DEPTH) : {1'b0, wr_ptr_q};
	assign rd_data = rd_data_q;

endmodule
